// File: hdl/arp_pkg.sv
// ----------------------------------------------------------------------------
// Arpeggio step sequencer package
// Shared constants, codes and helpers for the arpeggio step sequencer.
// ----------------------------------------------------------------------------
package arp_pkg;

	localparam int MAX_STEPS = 32;
	localparam int STEP_SPAN = 32;
	localparam int EFF_LIMIT = (MAX_STEPS < STEP_SPAN) ? MAX_STEPS : STEP_SPAN;

	localparam int STEP_W  = 5;
	localparam int COUNT_W = 6;
	localparam int MODE_W  = 3;
	localparam int OP_W    = 2;
	localparam int RND_W   = 8;
	localparam int DIR_W   = 2;
	localparam int IDX_W   = 2;

	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [OP_W-1:0]    opcode_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [RND_W-1:0]   rnd_t;
	typedef logic [IDX_W-1:0]   reg_idx_t;

	localparam mode_t MODE_UP        = 3'd0;
	localparam mode_t MODE_DOWN      = 3'd1;
	localparam mode_t MODE_UPDOWN    = 3'd2;
	localparam mode_t MODE_UPDOWN_RP = 3'd3;
	localparam mode_t MODE_RANDOM    = 3'd4;
	localparam mode_t MODE_CYCLE     = 3'd5;

	localparam opcode_t OP_ADVANCE = 2'd0;
	localparam opcode_t OP_RESTART = 2'd1;
	localparam opcode_t OP_LOAD    = 2'd2;

	localparam reg_idx_t REG_MODE  = 2'd0;
	localparam reg_idx_t REG_SIZE  = 2'd1;
	localparam reg_idx_t REG_RANGE = 2'd2;

	localparam count_t EFF_MAX = count_t'(EFF_LIMIT);

	typedef struct packed {
		logic   start;
		rnd_t   dividend;
		count_t divisor;
	} mod_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		step_t remainder;
	} mod_rsp_t;

	function automatic count_t eff_count(input count_t v);
		eff_count = (v > EFF_MAX) ? EFF_MAX : v;
	endfunction

endpackage

// File: hdl/arp_in_if.sv
// ----------------------------------------------------------------------------
// Arpeggio request channel
// Valid/ready channel carrying one sequencer request.
// ----------------------------------------------------------------------------
interface arp_in_if;
	import arp_pkg::*;

	logic    valid;
	logic    ready;
	opcode_t opcode;
	step_t   step_value;
	rnd_t    random_value;

	modport source (output valid, output opcode, output step_value, output random_value,
		input ready);
	modport sink (input valid, input opcode, input step_value, input random_value,
		output ready);
endinterface

// File: hdl/arp_out_if.sv
// ----------------------------------------------------------------------------
// Arpeggio result channel
// Valid/ready channel carrying the step and direction after each request.
// ----------------------------------------------------------------------------
interface arp_out_if;
	import arp_pkg::*;

	logic               valid;
	logic               ready;
	step_t              current_step;
	logic signed [1:0]  current_direction;

	modport source (output valid, output current_step, output current_direction,
		input ready);
	modport sink (input valid, input current_step, input current_direction,
		output ready);
endinterface

// File: hdl/arp_cfg_if.sv
// ----------------------------------------------------------------------------
// Arpeggio configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface arp_cfg_if;
	import arp_pkg::*;

	logic     valid;
	logic     ready;
	reg_idx_t index;
	count_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/arp_mod_unit.sv
// ----------------------------------------------------------------------------
// Arpeggio modulo unit
// Restoring remainder unit, one dividend bit per cycle; a new pass starts only when the unit is idle.
// ----------------------------------------------------------------------------
module arp_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  arp_pkg::mod_req_t req,
	output arp_pkg::mod_rsp_t rsp
);
	import arp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	rnd_t        dvd_q;
	count_t      dvs_q;
	step_t       rem_q;
	logic [5:0]  trial;
	logic        fits;
	step_t       rem_next;

	assign trial    = {rem_q, dvd_q[RND_W-1]};
	assign fits     = trial >= dvs_q;
	assign rem_next = fits ? step_t'(trial - dvs_q) : trial[STEP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
		end else if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("modulo done without a pass in flight");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, rem_q} < dvs_q))
		else $error("modulo remainder not below divisor");
endmodule

// File: hdl/arpeggio_step_sequencer_core.sv
// ----------------------------------------------------------------------------
// Arpeggio step sequencer core
// Advances, restarts or loads the arpeggio step in six pattern modes.
// ----------------------------------------------------------------------------
// A request without a modulo pass goes to the done state, and its result is then registered once the output is free.
// Up, random and restart-in-random take one pass of the modulo unit.
// Cycle mode with nonzero size and range takes one pass, or two passes when the inner counter wraps.
// One request is in flight at a time; a held result delays the next one in its final state.
// Reset clears the step state, sets direction up, and loads mode 0, size 1 and range 1.
module arpeggio_step_sequencer_core (
	input logic      clk,
	input logic      arst_n,
	arp_in_if.sink   step_in,
	arp_out_if.source step_out,
	arp_cfg_if.sink  cfg
);
	import arp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MOD  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t   state_q;
	mode_t    mode_q;
	count_t   size_q;
	count_t   range_q;
	step_t    step_q;
	step_t    inner_q;
	logic     down_q;
	logic     ec_q;
	logic     sp_q;
	logic     to_inner_q;
	logic     second_q;
	logic     out_valid_q;
	step_t    out_step_q;
	logic     out_down_q;

	mod_req_t mreq;
	mod_rsp_t mrsp;

	count_t   size_eff;
	count_t   range_eff;
	logic     accept;
	logic     chain;
	logic     out_load;

	step_t    n_step;
	step_t    n_inner;
	logic     n_down;
	logic     n_ec;
	logic     n_sp;
	logic     need_mod;
	logic     n_to_inner;
	logic     n_second;
	rnd_t     n_dvd;
	count_t   n_dvs;

	logic signed [6:0] nx;
	logic              d_down;
	logic [5:0]        inner_inc;
	logic [5:0]        step_inc;

	assign size_eff  = eff_count(size_q);
	assign range_eff = eff_count(range_q);
	assign accept    = step_in.valid && step_in.ready;
	assign chain     = (state_q == ST_MOD) && mrsp.done && second_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || step_out.ready);
	assign inner_inc = {1'b0, inner_q} + 6'd1;
	assign step_inc  = {1'b0, step_q} + 6'd1;
	assign nx        = $signed({2'b00, step_q}) + (down_q ? -7'sd1 : 7'sd1);

	always_comb begin
		n_step     = step_q;
		n_inner    = inner_q;
		n_down     = down_q;
		n_ec       = ec_q;
		n_sp       = sp_q;
		need_mod   = 1'b0;
		n_to_inner = 1'b0;
		n_second   = 1'b0;
		n_dvd      = '0;
		n_dvs      = size_eff;
		d_down     = down_q;
		case (step_in.opcode)
			OP_ADVANCE: begin
				case (mode_q)
					MODE_UP: begin
						n_down = 1'b0;
						if (size_eff != '0) begin
							need_mod = 1'b1;
							n_dvd    = {2'b00, step_inc};
						end else begin
							n_step = '0;
						end
					end
					MODE_DOWN: begin
						n_down = 1'b1;
						if (size_eff != '0)
							n_step = (step_q == '0) ? step_t'(size_eff - 6'd1) : step_q - 5'd1;
						else
							n_step = '0;
					end
					MODE_UPDOWN: begin
						if (size_eff > 6'd1) begin
							if (nx >= $signed({1'b0, size_eff})) d_down = 1'b1;
							if (nx < 7'sd0) d_down = 1'b0;
							n_down = d_down;
							n_step = d_down ? step_q - 5'd1 : step_q + 5'd1;
						end else begin
							n_step = '0;
						end
					end
					MODE_UPDOWN_RP: begin
						if (size_eff > 6'd1) begin
							if (!ec_q) begin
								if (nx >= $signed({1'b0, size_eff})) begin
									d_down = 1'b1;
									n_sp   = 1'b1;
									n_ec   = 1'b1;
								end
								if (nx < 7'sd0) begin
									d_down = 1'b0;
									n_sp   = 1'b1;
									n_ec   = 1'b1;
								end
							end
							n_down = d_down;
							if (!n_sp) begin
								n_step = d_down ? step_q - 5'd1 : step_q + 5'd1;
								n_ec   = 1'b0;
							end
							n_sp = 1'b0;
						end else begin
							n_step = '0;
						end
					end
					MODE_RANDOM: begin
						if (size_eff != '0) begin
							need_mod = 1'b1;
							n_dvd    = step_in.random_value;
						end else begin
							n_step = '0;
						end
					end
					MODE_CYCLE: begin
						n_down = 1'b0;
						if (size_eff != '0) begin
							if (range_eff != '0) begin
								need_mod   = 1'b1;
								n_to_inner = 1'b1;
								n_dvd      = {2'b00, inner_inc};
								n_second   = inner_inc >= size_eff;
							end
						end else begin
							n_step  = '0;
							n_inner = '0;
						end
					end
					default: begin
					end
				endcase
			end
			OP_RESTART: begin
				n_step  = '0;
				n_inner = '0;
				n_ec    = 1'b0;
				n_sp    = 1'b0;
				n_down  = (mode_q == MODE_DOWN);
				if ((mode_q == MODE_RANDOM) && (size_eff != '0)) begin
					need_mod = 1'b1;
					n_dvd    = step_in.random_value;
				end
			end
			OP_LOAD: begin
				n_step = step_in.step_value;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mreq.start    = (accept && need_mod) || chain;
		mreq.dividend = chain ? {2'b00, step_inc} : n_dvd;
		mreq.divisor  = chain ? range_eff : n_dvs;
	end

	arp_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign cfg.ready      = 1'b1;
	assign step_in.ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_UP;
			size_q      <= 6'd1;
			range_q     <= 6'd1;
			step_q      <= '0;
			inner_q     <= '0;
			down_q      <= 1'b0;
			ec_q        <= 1'b0;
			sp_q        <= 1'b0;
			to_inner_q  <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_MODE:  mode_q  <= cfg.data[MODE_W-1:0];
					REG_SIZE:  size_q  <= cfg.data;
					REG_RANGE: range_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (step_out.valid && step_out.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q     <= n_step;
						inner_q    <= n_inner;
						down_q     <= n_down;
						ec_q       <= n_ec;
						sp_q       <= n_sp;
						to_inner_q <= n_to_inner;
						second_q   <= n_second;
						state_q    <= need_mod ? ST_MOD : ST_DONE;
					end
				end
				ST_MOD: begin
					if (mrsp.done) begin
						if (to_inner_q)
							inner_q <= mrsp.remainder;
						else
							step_q <= mrsp.remainder;
						if (second_q) begin
							second_q   <= 1'b0;
							to_inner_q <= 1'b0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_step_q <= step_q;
			out_down_q <= down_q;
		end
	end

	assign step_out.valid             = out_valid_q;
	assign step_out.current_step      = out_step_q;
	assign step_out.current_direction = {out_down_q, 1'b1};

	a_ready_only_when_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_in.ready |-> !mrsp.busy)
		else $error("request taken while the modulo unit is busy");

	a_done_only_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> (state_q == ST_MOD))
		else $error("modulo result arrived outside the modulo state");

	a_second_pass_cycle_only: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (to_inner_q && (mode_q == MODE_CYCLE)))
		else $error("second modulo pass pending outside cycle mode");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without a finished request");
endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Arpeggio step sequencer core testbench
// Drives step requests and register writes with random gaps and output stalls,
// predicts the step and direction of every request, and compares each result
// in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import arp_pkg::*;

	localparam opcode_t  OP_UNUSED     = 2'd3;
	localparam mode_t    MODE_SPARE_LO = 3'd6;
	localparam mode_t    MODE_SPARE_HI = 3'd7;
	localparam reg_idx_t REG_UNUSED    = 2'd3;

	localparam int RANDOM_ITEMS  = 1700;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 40;

	typedef logic signed [1:0] dir_t;

	typedef struct {
		step_t step;
		dir_t  dir;
	} step_result_t;

	class step_tracker;
		mode_t        mode;
		count_t       size;
		count_t       range;
		step_t        pos;
		step_t        inner_pos;
		bit           down;
		bit           end_seen;
		bit           skip;
		step_result_t expected_steps[$];
		int           errors;
		int           checked;

		function new();
			mode = MODE_UP;
			size = 6'd1;
			range = 6'd1;
			pos = '0;
			inner_pos = '0;
			down = 1'b0;
			end_seen = 1'b0;
			skip = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function int clip(count_t v);
			return (int'(v) > EFF_LIMIT) ? EFF_LIMIT : int'(v);
		endfunction

		function void write_reg(reg_idx_t idx, count_t data);
			case (idx)
				REG_MODE: begin
					mode = data[MODE_W-1:0];
				end
				REG_SIZE: begin
					size = data;
				end
				REG_RANGE: begin
					range = data;
				end
				default: begin
				end
			endcase
		endfunction

		function void advance(rnd_t rnd);
			int sz;
			int rg;
			int s;
			int d;
			int nx;
			sz = clip(size);
			rg = clip(range);
			s = int'(pos);
			d = down ? -1 : 1;
			case (mode)
				MODE_UP: begin
					down = 1'b0;
					pos = (sz > 0) ? step_t'((s + 1) % sz) : '0;
				end
				MODE_DOWN: begin
					down = 1'b1;
					if (sz > 0)
						pos = (s == 0) ? step_t'(sz - 1) : step_t'(s - 1);
					else
						pos = '0;
				end
				MODE_UPDOWN: begin
					if (sz > 1) begin
						nx = s + d;
						if (nx >= sz)
							d = -1;
						if (nx < 0)
							d = 1;
						down = (d < 0);
						pos = step_t'(s + d);
					end else begin
						pos = '0;
					end
				end
				MODE_UPDOWN_RP: begin
					if (sz > 1) begin
						nx = s + d;
						if (!end_seen) begin
							if (nx >= sz) begin
								d = -1;
								skip = 1'b1;
								end_seen = 1'b1;
							end
							if (nx < 0) begin
								d = 1;
								skip = 1'b1;
								end_seen = 1'b1;
							end
						end
						down = (d < 0);
						if (!skip) begin
							pos = step_t'(s + d);
							end_seen = 1'b0;
						end
						skip = 1'b0;
					end else begin
						pos = '0;
					end
				end
				MODE_RANDOM: begin
					pos = (sz > 0) ? step_t'(int'(rnd) % sz) : '0;
				end
				MODE_CYCLE: begin
					down = 1'b0;
					if (sz >= 1) begin
						if (rg > 0) begin
							if (int'(inner_pos) + 1 >= sz)
								pos = step_t'((s + 1) % rg);
							inner_pos = step_t'((int'(inner_pos) + 1) % sz);
						end
					end else begin
						pos = '0;
						inner_pos = '0;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void restart(rnd_t rnd);
			int sz;
			sz = clip(size);
			pos = '0;
			inner_pos = '0;
			end_seen = 1'b0;
			skip = 1'b0;
			down = (mode == MODE_DOWN);
			if (mode == MODE_RANDOM)
				pos = (sz > 0) ? step_t'(int'(rnd) % sz) : '0;
		endfunction

		function void take_request(opcode_t op, step_t val, rnd_t rnd);
			step_result_t r;
			case (op)
				OP_ADVANCE: begin
					advance(rnd);
				end
				OP_RESTART: begin
					restart(rnd);
				end
				OP_LOAD: begin
					pos = val;
				end
				default: begin
				end
			endcase
			r.step = pos;
			r.dir = down ? -2'sd1 : 2'sd1;
			expected_steps.push_back(r);
		endfunction

		function void check_result(step_t got_step, dir_t got_dir);
			step_result_t e;
			if (expected_steps.size() == 0) begin
				$display("%0t: result with no request pending, step %0d direction %0d",
					$time, got_step, got_dir);
				errors++;
				return;
			end
			e = expected_steps.pop_front();
			checked++;
			if (got_step !== e.step) begin
				$display("%0t: current_step mismatch, expected %0d, actual %0d",
					$time, e.step, got_step);
				errors++;
			end
			if (got_dir !== e.dir) begin
				$display("%0t: current_direction mismatch, expected %0d, actual %0d",
					$time, e.dir, got_dir);
				errors++;
			end
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	arp_in_if  step_in();
	arp_out_if step_out();
	arp_cfg_if cfg();

	step_tracker tracker = new();
	bit stall_on;
	int requests_sent;
	int settings;
	int cycles;

	arpeggio_step_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.step_in(step_in),
		.step_out(step_out),
		.cfg(cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (step_out.valid === 1'b1 && step_out.ready === 1'b1)
				tracker.check_result(step_out.current_step, step_out.current_direction);
			if (step_in.valid === 1'b1 && step_in.ready === 1'b1)
				tracker.take_request(step_in.opcode, step_in.step_value,
					step_in.random_value);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding",
			CYCLE_LIMIT, tracker.pending());
		$display("** arpeggio_step_sequencer_core: FAILED **");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!stall_on)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic count_t pick_count();
		case ($urandom_range(0, 7))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd2;
			3: return 6'd32;
			4: return count_t'($urandom_range(33, 63));
			7: return count_t'($urandom_range(0, 63));
			default: return count_t'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic mode_t pick_mode();
		int r;
		r = $urandom_range(0, 13);
		if (r == 12)
			return MODE_SPARE_LO;
		if (r == 13)
			return MODE_SPARE_HI;
		return mode_t'(r % 6);
	endfunction

	task automatic drive_result_ready();
		int hold;
		int r;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!stall_on) begin
				step_out.ready <= 1'b1;
				hold = 7;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					step_out.ready <= 1'b1;
					hold = $urandom_range(0, 6);
				end else if (r < 9) begin
					step_out.ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end else begin
					step_out.ready <= 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	endtask

	task automatic send_request(opcode_t op, step_t val, rnd_t rnd);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			step_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_in.valid <= 1'b1;
		step_in.opcode <= op;
		step_in.step_value <= val;
		step_in.random_value <= rnd;
		do
			@(posedge clk);
		while (step_in.ready !== 1'b1);
		requests_sent++;
	endtask

	task automatic drain();
		step_in.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() > 0);
	endtask

	task automatic write_reg(reg_idx_t idx, count_t data);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do
			@(posedge clk);
		while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		tracker.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic set_pattern(mode_t mode, count_t size, count_t range);
		write_reg(REG_MODE, count_t'(mode));
		write_reg(REG_SIZE, size);
		write_reg(REG_RANGE, range);
		settings++;
	endtask

	initial begin
		int n;
		int r;
		int random_count;
		opcode_t op;

		random_count = 0;
		requests_sent = 0;
		settings = 0;
		stall_on = 1'b0;
		arst_n <= 1'b0;
		step_in.valid <= 1'b0;
		step_in.opcode <= OP_ADVANCE;
		step_in.step_value <= '0;
		step_in.random_value <= '0;
		step_out.ready <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_MODE;
		cfg.data <= '0;
		fork
			drive_result_ready();
		join_none
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests: reset settings, range extremes and the edge behaviors.
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		send_request(OP_LOAD, 5'd31, 8'd0);
		send_request(OP_ADVANCE, 5'd0, 8'hff);
		send_request(OP_UNUSED, 5'd31, 8'hff);
		send_request(OP_RESTART, 5'd0, 8'd0);
		set_pattern(MODE_DOWN, 6'd32, 6'd1);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		send_request(OP_RESTART, 5'd0, 8'd0);
		set_pattern(MODE_UPDOWN_RP, 6'd2, 6'd1);
		repeat (4) send_request(OP_ADVANCE, 5'd0, 8'd0);
		set_pattern(MODE_RANDOM, 6'd0, 6'd1);
		send_request(OP_ADVANCE, 5'd0, 8'hff);
		send_request(OP_RESTART, 5'd0, 8'hff);
		write_reg(REG_SIZE, 6'd63);
		send_request(OP_ADVANCE, 5'd0, 8'hff);
		send_request(OP_RESTART, 5'd0, 8'd200);
		set_pattern(MODE_CYCLE, 6'd1, 6'd0);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		write_reg(REG_RANGE, 6'd63);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		write_reg(REG_SIZE, 6'd0);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		set_pattern(MODE_SPARE_HI, 6'd3, 6'd3);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		send_request(OP_RESTART, 5'd0, 8'd0);
		write_reg(REG_UNUSED, 6'h3f);
		set_pattern(MODE_UPDOWN, 6'd1, 6'd1);
		send_request(OP_ADVANCE, 5'd0, 8'd0);
		send_request(OP_LOAD, 5'd20, 8'd0);
		write_reg(REG_SIZE, 6'd3);
		send_request(OP_ADVANCE, 5'd0, 8'd0);

		while (random_count < RANDOM_ITEMS) begin
			stall_on = ($urandom_range(0, 3) != 0);
			set_pattern(pick_mode(), pick_count(), pick_count());
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, count_t'($urandom));
			n = $urandom_range(20, 60);
			repeat (n) begin
				r = $urandom_range(0, 19);
				if (r < 14)
					op = OP_ADVANCE;
				else if (r < 16)
					op = OP_RESTART;
				else if (r < 19)
					op = OP_LOAD;
				else
					op = OP_UNUSED;
				send_request(op, step_t'($urandom), rnd_t'($urandom));
				if (op != OP_UNUSED)
					random_count++;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d step requests under %0d register settings, %0d results checked.",
			requests_sent, settings, tracker.checked);
		$display("All pattern modes, spare mode codes, oversized sizes and empty patterns ran.");
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("** arpeggio_step_sequencer_core: PASSED **");
		else
			$display("** arpeggio_step_sequencer_core: FAILED **");
		$finish;
	end
endmodule

// File: filelist.f
hdl/arp_pkg.sv
hdl/arp_in_if.sv
hdl/arp_out_if.sv
hdl/arp_cfg_if.sv
hdl/arp_mod_unit.sv
hdl/arpeggio_step_sequencer_core.sv
dv/tb.sv
